// ----- hdl/vbma_pkg.sv -----
package vbma_pkg;

   // Field and port widths.
   localparam int SAMPLE_W   = 12;
   localparam int TEMP_F_W   = 14;
   localparam int STATUS_W   = 2;
   localparam int NVALID_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Burst and window sizes.
   localparam int SAMPLES_PER_READ = 4;
   localparam int WINDOW_LENGTH    = 5;

   localparam logic signed [SAMPLE_W-1:0] DISCONNECTED_CODE = -12'sd2032;
   localparam logic signed [SAMPLE_W-1:0] MIN_VALID_RESET   = -12'sd880;
   localparam logic signed [SAMPLE_W-1:0] MAX_VALID_RESET   = 12'sd2000;
   localparam logic signed [SAMPLE_W-1:0] HELD_RESET        = 12'sd400;
   localparam logic signed [TEMP_F_W-1:0] F_OFFSET          = 14'sd512;
   localparam int F_DIVISOR = 5;
   localparam int F_DIV_W   = $clog2(F_DIVISOR + 1);

   // Derived widths.
   localparam int POS_W   = $clog2(SAMPLES_PER_READ + 1);
   localparam int CNT_W   = $clog2(SAMPLES_PER_READ + 1);
   localparam int SUM_W   = SAMPLE_W + CNT_W;
   localparam int WIDX_W  = $clog2(WINDOW_LENGTH);
   localparam int WCNT_W  = $clog2(WINDOW_LENGTH + 1);
   localparam int WSUM_W  = SAMPLE_W + WCNT_W;
   localparam int FPROD_W = SAMPLE_W + 4;
   localparam int DIV_W0  = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;
   localparam int DIV_W   = (DIV_W0 > FPROD_W) ? DIV_W0 : FPROD_W;
   localparam int DVS_W0  = (CNT_W > WCNT_W) ? CNT_W : WCNT_W;
   localparam int DVS_W   = (DVS_W0 > F_DIV_W) ? DVS_W0 : F_DIV_W;
   localparam int STEP_W  = $clog2(DIV_W + 1);

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SENSOR   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALL_INVALID = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_PRESENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALID      = 2'd2;

   typedef struct packed {
      logic step;
      logic drop;
   } acc_ctl_type;

   typedef struct packed {
      logic                    last;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } acc_stat_type;

   typedef struct packed {
      logic                       wr;
      logic signed [SAMPLE_W-1:0] value;
   } win_ctl_type;

   typedef struct packed {
      logic signed [WSUM_W-1:0] sum;
      logic [WCNT_W-1:0]        count;
   } win_stat_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_stat_type;

   // Celsius times nine, by shift and add.
   function automatic logic signed [DIV_W-1:0] times_nine(input logic signed [SAMPLE_W-1:0] v);
      logic signed [DIV_W-1:0] x;
      x = DIV_W'(v);
      return (x <<< 3) + x;
   endfunction

endpackage

// ----- hdl/validated_burst_moving_average.sv -----
// Validated burst moving average for a temperature sensor.
// Requests arrive on req_valid/req_stall, one raw sample each with its filtered flag. Every
// SAMPLES_PER_READ requests form a read; only the request that closes a read (or any request
// while sensor_present is clear) gives a result on rsp_valid/rsp_stall, with Celsius and
// Fahrenheit in 1/16 degree, a status code and the count of accepted samples.
// A request that does not close a read only updates the burst and raises no stall. Other
// requests run the shared bit-serial divider: one division for the burst average, one more
// for the window average when filtered, and one for the Fahrenheit scaling; a request that
// reports the held value runs only the Fahrenheit scaling. req_stall stays high until the
// result is loaded into the output register.
// The result sits in an output register, so requests keep being taken while it waits.
// If the receiver stalls and a second result is ready, the block holds it and stalls
// requests until the output register frees up.
// Synchronous reset clears the burst, empties the window, sets the held value to 25.0 C and
// restores the registers to sensor absent and the range -55 C to 125 C. Registers must be
// written through csr_write/csr_index/csr_data while idle; the block does not enforce it.
module validated_burst_moving_average (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [vbma_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                                    req_filtered,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [vbma_pkg::SAMPLE_W-1:0]    rsp_temp_c,
   output logic signed [vbma_pkg::TEMP_F_W-1:0]    rsp_temp_f,
   output logic [vbma_pkg::STATUS_W-1:0]           rsp_status,
   output logic [vbma_pkg::NVALID_W-1:0]           rsp_valid_samples,
   input  logic                                    csr_write,
   input  logic [vbma_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [vbma_pkg::CSR_DATA_W-1:0]         csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_AVG,
      ST_DIV_WIN,
      ST_DIV_F,
      ST_OUT_WAIT
   } state_type;

   state_type                            state_ff, state_in;

   // Configuration registers.
   logic                                 sensor_present_ff;
   logic signed [vbma_pkg::SAMPLE_W-1:0] min_valid_ff;
   logic signed [vbma_pkg::SAMPLE_W-1:0] max_valid_ff;

   // Working registers for the result being computed.
   logic signed [vbma_pkg::SAMPLE_W-1:0] held_ff, held_in;
   logic signed [vbma_pkg::SAMPLE_W-1:0] res_c_ff, res_c_in;
   logic signed [vbma_pkg::TEMP_F_W-1:0] res_f_ff, res_f_in;
   logic [vbma_pkg::STATUS_W-1:0]        res_status_ff, res_status_in;
   logic [vbma_pkg::CNT_W-1:0]           res_nvalid_ff, res_nvalid_in;
   logic                                 filt_ff, filt_in;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [vbma_pkg::SAMPLE_W-1:0] rsp_temp_c_ff, rsp_temp_c_in;
   logic signed [vbma_pkg::TEMP_F_W-1:0] rsp_temp_f_ff, rsp_temp_f_in;
   logic [vbma_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [vbma_pkg::NVALID_W-1:0]        rsp_nvalid_ff, rsp_nvalid_in;

   logic                                 req_accept;
   logic signed [vbma_pkg::SAMPLE_W-1:0] quo_c;

   vbma_pkg::acc_ctl_type                acc_ctl;
   vbma_pkg::acc_stat_type               acc_stat;
   vbma_pkg::win_ctl_type                win_ctl;
   vbma_pkg::win_stat_type               win_stat;
   vbma_pkg::div_req_type                div_req;
   vbma_pkg::div_stat_type               div_stat;

   vbma_burst_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (acc_ctl),
      .sample    (req_sample),
      .min_valid (min_valid_ff),
      .max_valid (max_valid_ff),
      .stat      (acc_stat)
   );

   vbma_window u_win (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .stat  (win_stat)
   );

   vbma_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   // The block only takes requests between results.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign quo_c      = vbma_pkg::SAMPLE_W'(div_stat.quotient);

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_present_ff <= 1'b0;
         min_valid_ff      <= vbma_pkg::MIN_VALID_RESET;
         max_valid_ff      <= vbma_pkg::MAX_VALID_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            vbma_pkg::CSR_SENSOR_PRESENT: sensor_present_ff <= csr_data[0];
            vbma_pkg::CSR_MIN_VALID:      min_valid_ff      <= signed'(csr_data);
            vbma_pkg::CSR_MAX_VALID:      max_valid_ff      <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      res_c_in      = res_c_ff;
      res_f_in      = res_f_ff;
      res_status_in = res_status_ff;
      res_nvalid_in = res_nvalid_ff;
      filt_in       = filt_ff;

      // The output register empties when the receiver takes the result.
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_temp_c_in = rsp_temp_c_ff;
      rsp_temp_f_in = rsp_temp_f_ff;
      rsp_status_in = rsp_status_ff;
      rsp_nvalid_in = rsp_nvalid_ff;

      acc_ctl.step     = 1'b0;
      acc_ctl.drop     = 1'b0;
      win_ctl.wr       = 1'b0;
      win_ctl.value    = quo_c;
      div_req.start    = 1'b0;
      div_req.dividend = vbma_pkg::times_nine(held_ff);
      div_req.divisor  = vbma_pkg::DVS_W'(vbma_pkg::F_DIVISOR);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!sensor_present_ff) begin
                  // No sensor: discard the partial read and report the held value.
                  acc_ctl.drop  = 1'b1;
                  res_c_in      = held_ff;
                  res_status_in = vbma_pkg::STATUS_NO_SENSOR;
                  res_nvalid_in = '0;
                  div_req.start = 1'b1;
                  state_in      = ST_DIV_F;
               end else begin
                  acc_ctl.step = 1'b1;
                  if (acc_stat.last) begin
                     if (acc_stat.count == '0) begin
                        // Every sample of the read was rejected.
                        res_c_in      = held_ff;
                        res_status_in = vbma_pkg::STATUS_ALL_INVALID;
                        res_nvalid_in = '0;
                        div_req.start = 1'b1;
                        state_in      = ST_DIV_F;
                     end else begin
                        res_status_in    = vbma_pkg::STATUS_OK;
                        res_nvalid_in    = acc_stat.count;
                        filt_in          = req_filtered;
                        div_req.start    = 1'b1;
                        div_req.dividend = vbma_pkg::DIV_W'(acc_stat.sum);
                        div_req.divisor  = vbma_pkg::DVS_W'(acc_stat.count);
                        state_in         = ST_DIV_AVG;
                     end
                  end
               end
            end
         end
         ST_DIV_AVG: begin
            if (div_stat.done) begin
               div_req.start = 1'b1;
               if (filt_ff) begin
                  // Push the burst average into the window and average the window.
                  win_ctl.wr       = 1'b1;
                  div_req.dividend = vbma_pkg::DIV_W'(win_stat.sum);
                  div_req.divisor  = vbma_pkg::DVS_W'(win_stat.count);
                  state_in         = ST_DIV_WIN;
               end else begin
                  res_c_in         = quo_c;
                  held_in          = quo_c;
                  div_req.dividend = vbma_pkg::times_nine(quo_c);
                  state_in         = ST_DIV_F;
               end
            end
         end
         ST_DIV_WIN: begin
            if (div_stat.done) begin
               res_c_in         = quo_c;
               held_in          = quo_c;
               div_req.start    = 1'b1;
               div_req.dividend = vbma_pkg::times_nine(quo_c);
               state_in         = ST_DIV_F;
            end
         end
         ST_DIV_F: begin
            if (div_stat.done) begin
               res_f_in = vbma_pkg::TEMP_F_W'(div_stat.quotient) + vbma_pkg::F_OFFSET;
               state_in = ST_OUT_WAIT;
            end
         end
         ST_OUT_WAIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_temp_c_in = res_c_ff;
               rsp_temp_f_in = res_f_ff;
               rsp_status_in = res_status_ff;
               rsp_nvalid_in = vbma_pkg::NVALID_W'(res_nvalid_ff);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= vbma_pkg::HELD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_c_ff      <= res_c_in;
      res_f_ff      <= res_f_in;
      res_status_ff <= res_status_in;
      res_nvalid_ff <= res_nvalid_in;
      filt_ff       <= filt_in;
      rsp_temp_c_ff <= rsp_temp_c_in;
      rsp_temp_f_ff <= rsp_temp_f_in;
      rsp_status_ff <= rsp_status_in;
      rsp_nvalid_ff <= rsp_nvalid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temp_c        = rsp_temp_c_ff;
   assign rsp_temp_f        = rsp_temp_f_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_valid_samples = rsp_nvalid_ff;

   // While the divider works, no request may be taken.
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> req_stall)
      else $error("request taken while the divider is busy");

   // A division only finishes while the controller waits for one.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV_AVG || state_ff == ST_DIV_WIN
                         || state_ff == ST_DIV_F))
      else $error("divider finished outside a division state");

   // A good result counts at least one sample; a held result counts none.
   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == vbma_pkg::STATUS_OK) == (rsp_valid_samples != '0)))
      else $error("status and accepted sample count disagree");

endmodule

// ----- hdl/vbma_serial_div.sv -----
// Signed by unsigned restoring divider, one quotient bit per cycle, truncating toward zero.
module vbma_serial_div (
   input  logic                   clock,
   input  logic                   reset,
   input  vbma_pkg::div_req_type  req,
   output vbma_pkg::div_stat_type stat
);

   logic [vbma_pkg::STEP_W-1:0]  count_ff, count_in;
   logic                         done_ff, done_in;
   logic                         neg_ff, neg_in;
   logic [vbma_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [vbma_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [vbma_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [vbma_pkg::DIV_W-1:0]   mag;
   logic [vbma_pkg::DVS_W:0]     trial;
   logic                         ge;

   always_comb begin
      mag   = req.dividend[vbma_pkg::DIV_W-1] ? (~req.dividend + 1'b1) : req.dividend;
      trial = {rem_ff, quo_ff[vbma_pkg::DIV_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});

      count_in = count_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;

      if (req.start) begin
         count_in = vbma_pkg::STEP_W'(vbma_pkg::DIV_W);
         neg_in   = req.dividend[vbma_pkg::DIV_W-1];
         quo_in   = mag;
         rem_in   = '0;
         dvs_in   = req.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == vbma_pkg::STEP_W'(1));
         rem_in   = ge ? vbma_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                       : vbma_pkg::DVS_W'(trial);
         quo_in   = {quo_ff[vbma_pkg::DIV_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy     = (count_ff != '0);
   assign stat.done     = done_ff;
   assign stat.quotient = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);

endmodule

// ----- hdl/vbma_burst_acc.sv -----
// Sample validation and per-burst sum and count.
module vbma_burst_acc (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vbma_pkg::acc_ctl_type                 ctl,
   input  logic signed [vbma_pkg::SAMPLE_W-1:0]  sample,
   input  logic signed [vbma_pkg::SAMPLE_W-1:0]  min_valid,
   input  logic signed [vbma_pkg::SAMPLE_W-1:0]  max_valid,
   output vbma_pkg::acc_stat_type                stat
);

   logic [vbma_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [vbma_pkg::CNT_W-1:0]        count_ff, count_in;
   logic signed [vbma_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                              ok;

   always_comb begin
      ok = (sample != vbma_pkg::DISCONNECTED_CODE) && (sample >= min_valid)
           && (sample <= max_valid);
      stat.last  = (pos_ff == vbma_pkg::POS_W'(vbma_pkg::SAMPLES_PER_READ - 1));
      stat.sum   = ok ? sum_ff + vbma_pkg::SUM_W'(sample) : sum_ff;
      stat.count = count_ff + vbma_pkg::CNT_W'(ok);

      pos_in   = pos_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (ctl.drop || (ctl.step && stat.last)) begin
         pos_in   = '0;
         count_in = '0;
         sum_in   = '0;
      end else if (ctl.step) begin
         pos_in   = pos_ff + 1'b1;
         count_in = stat.count;
         sum_in   = stat.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ----- hdl/vbma_window.sv -----
// Moving-average window with a running sum; the entry being replaced is subtracted once full.
module vbma_window (
   input  logic                   clock,
   input  logic                   reset,
   input  vbma_pkg::win_ctl_type  ctl,
   output vbma_pkg::win_stat_type stat
);

   logic signed [vbma_pkg::SAMPLE_W-1:0] store_ff [vbma_pkg::WINDOW_LENGTH];
   logic [vbma_pkg::WIDX_W-1:0]          idx_ff, idx_in;
   logic                                 full_ff, full_in;
   logic signed [vbma_pkg::WSUM_W-1:0]   wsum_ff, wsum_in;
   logic signed [vbma_pkg::WSUM_W-1:0]   old;
   logic                                 wrap;

   always_comb begin
      wrap    = (idx_ff == vbma_pkg::WIDX_W'(vbma_pkg::WINDOW_LENGTH - 1));
      old     = full_ff ? vbma_pkg::WSUM_W'(store_ff[idx_ff]) : '0;
      idx_in  = wrap ? '0 : idx_ff + 1'b1;
      full_in = full_ff | wrap;
      wsum_in = wsum_ff + vbma_pkg::WSUM_W'(ctl.value) - old;
      stat.sum   = wsum_in;
      stat.count = full_in ? vbma_pkg::WCNT_W'(vbma_pkg::WINDOW_LENGTH)
                           : vbma_pkg::WCNT_W'(idx_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         full_ff <= 1'b0;
         wsum_ff <= '0;
      end else if (ctl.wr) begin
         idx_ff  <= idx_in;
         full_ff <= full_in;
         wsum_ff <= wsum_in;
      end
      if (ctl.wr) begin
         store_ff[idx_ff] <= ctl.value;
      end
   end

endmodule
